### rtl/buddy_page_allocator_assert.svh
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("buddy page allocator check failed");
`define BPA_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("buddy page allocator reset check failed");
`else
`define BPA_ASSERT(lbl, clk, rst_n, prop)
`define BPA_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### rtl/bpa_pkg.sv
// Shared types and constants of the buddy page allocator.
package bpa_pkg;
    localparam int PAGE_W     = 20;
    localparam int ORDER_W    = 4;
    localparam int BCNT_W     = 5;
    localparam int STATUS_W   = 2;
    localparam int LEVEL_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE = 5'd31;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [PAGE_W-1:0] FIRST_PAGE_RST  = 20'd0;
    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD_REQ,
        OP_SET_ALLOC,
        OP_HEAD_TAKE,
        OP_SET_FREE,
        OP_READ,
        OP_SET_BUDDY,
        OP_UNLINK_A,
        OP_UNLINK_B,
        OP_PUSH,
        OP_MERGED,
        OP_SET_PUSH_P,
        OP_SPLIT,
        OP_LOAD_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [STATUS_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic bad_req;
        logic is_free;
        logic none_free;
        logic level_listed;
        logic buddy_match;
        logic order_below_max;
        logic order_above_req;
        logic out_free;
    } t_dp_stat;
endpackage

### rtl/bpa_req_if.sv
// Request channel: valid/ready with the request fields.
interface bpa_req_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [ORDER_W-1:0] block_order;
    logic [PAGE_W-1:0]  page_number;

    modport source (output valid, output func, output block_order, output page_number,
                    input ready);
    modport sink   (input valid, input func, input block_order, input page_number,
                    output ready);
endinterface

### rtl/bpa_rsp_if.sv
// Result channel: valid/ready with status and page.
interface bpa_rsp_if import bpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_out;

    modport source (output valid, output status, output page_out, input ready);
    modport sink   (input valid, input status, input page_out, output ready);
endinterface

### rtl/bpa_datapath.sv
// Datapath: page memories, list heads, working registers and result register.
module bpa_datapath import bpa_pkg::*; #(
    parameter int MAX_ORDER = 10,
    parameter int NUM_PAGES = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_func,
    input  logic [ORDER_W-1:0]    i_block_order,
    input  logic [PAGE_W-1:0]     i_page_number,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [PAGE_W-1:0]     o_page_out,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);
    localparam int AW         = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LW         = $clog2(NUM_PAGES + 1);
    localparam int OW         = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int MAX_BLOCKS = NUM_PAGES >> MAX_ORDER;
    localparam logic [LW-1:0] NO_LINK = LW'(NUM_PAGES);

    logic [PAGE_W-1:0]  r_first_page;
    logic [BCNT_W-1:0]  r_block_count;
    logic [AW-1:0]      r_clr;
    logic               r_func;
    logic [ORDER_W-1:0] r_ord;
    logic [PAGE_W-1:0]  r_pnum;
    logic [AW-1:0]      r_p;
    logic [AW-1:0]      r_x;
    logic [OW-1:0]      r_o;
    logic [LW-1:0]      r_head [MAX_ORDER+1];
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [PAGE_W-1:0]   r_page_out;

    logic [LEVEL_W-1:0] mem_level [NUM_PAGES];
    logic [LW-1:0]      mem_next  [NUM_PAGES];
    logic [LW-1:0]      mem_prev  [NUM_PAGES];
    logic [LEVEL_W-1:0] r_rd_level;
    logic [LW-1:0]      r_rd_next;
    logic [LW-1:0]      r_rd_prev;

    logic [BCNT_W-1:0]  n_blk;
    logic [PAGE_W:0]    managed;
    logic [31:0]        clr_i;
    logic [31:0]        clr_k;
    logic               clr_head;
    logic [LEVEL_W-1:0] clr_level;
    logic [LW-1:0]      clr_next;
    logic [LW-1:0]      clr_prev;
    logic [LW-1:0]      top_head;
    logic [PAGE_W-1:0]  off;
    logic               bad_order;
    logic               misalign;
    logic [MAX_ORDER:0] nonempty;
    logic [MAX_ORDER:0] allowed;
    logic [OW-1:0]      found;
    logic [LW-1:0]      cur_head;
    logic               listed;
    logic               pv_valid;
    logic               nx_valid;

    logic               lv_we;
    logic [AW-1:0]      lv_wa;
    logic [LEVEL_W-1:0] lv_wd;
    logic               nx_we;
    logic [AW-1:0]      nx_wa;
    logic [LW-1:0]      nx_wd;
    logic               pv_we;
    logic [AW-1:0]      pv_wa;
    logic [LW-1:0]      pv_wd;

    always_comb begin
        n_blk   = (32'(r_block_count) < MAX_BLOCKS) ? r_block_count : BCNT_W'(MAX_BLOCKS);
        managed = (PAGE_W+1)'(32'(n_blk) << MAX_ORDER);
        // rebuilt state of one page: top-order heads chained, highest at the front
        clr_i    = 32'(r_clr);
        clr_k    = clr_i >> MAX_ORDER;
        clr_head = ((clr_i & ((32'd1 << MAX_ORDER) - 32'd1)) == 32'd0) && (clr_k < 32'(n_blk));
        clr_level = clr_head ? LEVEL_W'(MAX_ORDER) : LEVEL_NONE;
        clr_next  = (clr_head && clr_k > 32'd0) ? LW'((clr_k - 32'd1) << MAX_ORDER) : NO_LINK;
        clr_prev  = (clr_head && (clr_k + 32'd1) < 32'(n_blk))
                    ? LW'((clr_k + 32'd1) << MAX_ORDER) : NO_LINK;
        top_head  = (n_blk != '0) ? LW'((32'(n_blk) - 32'd1) << MAX_ORDER) : NO_LINK;
    end

    always_comb begin
        off       = r_pnum - r_first_page;
        bad_order = 32'(r_ord) > MAX_ORDER;
        misalign  = (off & ~({PAGE_W{1'b1}} << r_ord)) != '0;
        for (int i = 0; i <= MAX_ORDER; i++) begin
            nonempty[i] = r_head[i] != NO_LINK;
            allowed[i]  = 32'(i) >= 32'(r_ord);
        end
        found = '0;
        for (int i = MAX_ORDER; i >= 0; i--) begin
            if (nonempty[i] && allowed[i]) begin
                found = OW'(i);
            end
        end
        cur_head = r_head[r_o];
        listed   = 32'(r_rd_level) <= MAX_ORDER;
        pv_valid = r_rd_prev != NO_LINK;
        nx_valid = r_rd_next != NO_LINK;
    end

    always_comb begin
        o_stat.clr_last        = r_clr == AW'(NUM_PAGES - 1);
        o_stat.bad_req         = bad_order || (r_func == FUNC_FREE &&
                                 (r_pnum < r_first_page || {1'b0, off} >= managed || misalign));
        o_stat.is_free         = r_func == FUNC_FREE;
        o_stat.none_free       = (nonempty & allowed) == '0;
        o_stat.level_listed    = listed;
        o_stat.buddy_match     = r_rd_level == LEVEL_W'(r_o);
        o_stat.order_below_max = 32'(r_o) < MAX_ORDER;
        o_stat.order_above_req = 32'(r_o) > 32'(r_ord);
        o_stat.out_free        = !r_out_valid || i_out_ready;
    end

    // memory write ports
    always_comb begin
        lv_we = 1'b0; lv_wa = r_x; lv_wd = LEVEL_NONE;
        nx_we = 1'b0; nx_wa = r_x; nx_wd = NO_LINK;
        pv_we = 1'b0; pv_wa = r_x; pv_wd = NO_LINK;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                lv_we = 1'b1; lv_wa = r_clr; lv_wd = clr_level;
                nx_we = 1'b1; nx_wa = r_clr; nx_wd = clr_next;
                pv_we = 1'b1; pv_wa = r_clr; pv_wd = clr_prev;
            end
            OP_UNLINK_A: begin
                nx_we = listed && pv_valid; nx_wa = AW'(r_rd_prev); nx_wd = r_rd_next;
                pv_we = listed && nx_valid; pv_wa = AW'(r_rd_next); pv_wd = r_rd_prev;
            end
            OP_UNLINK_B: begin
                lv_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            OP_PUSH: begin
                lv_we = 1'b1; lv_wd = LEVEL_W'(r_o);
                nx_we = 1'b1; nx_wd = cur_head;
                pv_we = cur_head != NO_LINK; pv_wa = AW'(cur_head); pv_wd = LW'(r_x);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lv_we) mem_level[lv_wa] <= lv_wd;
        if (nx_we) mem_next[nx_wa] <= nx_wd;
        if (pv_we) mem_prev[pv_wa] <= pv_wd;
        if (i_cmd.op == OP_READ) begin
            r_rd_level <= mem_level[r_x];
            r_rd_next  <= mem_next[r_x];
            r_rd_prev  <= mem_prev[r_x];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CLEAR: begin
                for (int i = 0; i < MAX_ORDER; i++) begin
                    r_head[i] <= NO_LINK;
                end
                r_head[MAX_ORDER] <= top_head;
            end
            OP_UNLINK_A: begin
                if (listed && !pv_valid) r_head[r_rd_level[OW-1:0]] <= r_rd_next;
            end
            OP_PUSH: r_head[r_o] <= LW'(r_x);
            OP_LOAD_REQ: begin
                r_func <= i_func;
                r_ord  <= i_block_order;
                r_pnum <= i_page_number;
            end
            OP_SET_ALLOC: r_o <= found;
            OP_HEAD_TAKE: begin
                r_p <= AW'(cur_head);
                r_x <= AW'(cur_head);
            end
            OP_SET_FREE: begin
                r_p <= AW'(off);
                r_x <= AW'(off);
                r_o <= OW'(r_ord);
            end
            OP_SET_BUDDY: r_x <= r_p ^ (AW'(1) << r_o);
            OP_MERGED: begin
                r_p <= r_p & r_x;
                r_o <= r_o + OW'(1);
            end
            OP_SET_PUSH_P: r_x <= r_p;
            OP_SPLIT: begin
                r_o <= r_o - OW'(1);
                r_x <= r_p + (AW'(1) << (r_o - OW'(1)));
            end
            OP_LOAD_OUT: begin
                r_status   <= i_cmd.status;
                r_page_out <= (i_cmd.status == ST_OK && r_func == FUNC_ALLOC)
                              ? r_first_page + PAGE_W'(r_p) : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page  <= FIRST_PAGE_RST;
            r_block_count <= BLOCK_COUNT_RST;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIRST_PAGE:  r_first_page  <= i_cfg_data;
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[BCNT_W-1:0];
                    default: begin
                    end
                endcase
                r_clr <= '0;
            end else if (i_cmd.op == OP_CLEAR && !o_stat.clr_last) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.op == OP_LOAD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_page_out  = r_page_out;
endmodule

### rtl/bpa_ctrl.sv
// Controller: sequences rebuild, search, unlink, push, merge and split steps.
`include "buddy_page_allocator_assert.svh"
module bpa_ctrl import bpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_AHEAD, S_FREAD, S_FCHK, S_MERGE, S_BREAD,
        S_BCHK, S_MERGED, S_UREAD, S_UA, S_UB, S_PUSH, S_SPLIT, S_DONE
    } t_state;

    typedef enum logic [1:0] {RET_SPLIT, RET_MERGE, RET_PUSH} t_ret;

    t_state              r_state, n_state;
    t_ret                r_ret, n_ret;
    logic [STATUS_W-1:0] r_status, n_status;

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_status     = r_status;
        o_cmd.op     = OP_NOP;
        o_cmd.status = r_status;
        o_in_ready   = r_state == S_IDLE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD_REQ;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_stat.bad_req) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else if (i_stat.is_free) begin
                    o_cmd.op = OP_SET_FREE;
                    n_state  = S_FREAD;
                end else if (i_stat.none_free) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SET_ALLOC;
                    n_state  = S_AHEAD;
                end
            end
            S_AHEAD: begin
                o_cmd.op = OP_HEAD_TAKE;
                n_ret    = RET_SPLIT;
                n_state  = S_UREAD;
            end
            S_FREAD: begin
                o_cmd.op = OP_READ;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                // a page already listed as a free head is a double free
                if (i_stat.level_listed) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (i_stat.order_below_max) begin
                    o_cmd.op = OP_SET_BUDDY;
                    n_state  = S_BREAD;
                end else begin
                    o_cmd.op = OP_SET_PUSH_P;
                    n_ret    = RET_PUSH;
                    n_state  = S_UREAD;
                end
            end
            S_BREAD: begin
                o_cmd.op = OP_READ;
                n_state  = S_BCHK;
            end
            S_BCHK: begin
                // buddy data is already read: go straight to the unlink
                if (i_stat.buddy_match) begin
                    n_ret   = RET_MERGE;
                    n_state = S_UA;
                end else begin
                    o_cmd.op = OP_SET_PUSH_P;
                    n_ret    = RET_PUSH;
                    n_state  = S_UREAD;
                end
            end
            S_MERGED: begin
                o_cmd.op = OP_MERGED;
                n_state  = S_MERGE;
            end
            S_UREAD: begin
                o_cmd.op = OP_READ;
                n_state  = S_UA;
            end
            S_UA: begin
                o_cmd.op = OP_UNLINK_A;
                n_state  = S_UB;
            end
            S_UB: begin
                o_cmd.op = OP_UNLINK_B;
                unique case (r_ret)
                    RET_SPLIT: n_state = S_SPLIT;
                    RET_MERGE: n_state = S_MERGED;
                    RET_PUSH:  n_state = S_PUSH;
                    default:   n_state = S_PUSH;
                endcase
            end
            S_PUSH: begin
                o_cmd.op = OP_PUSH;
                if (i_stat.is_free) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (i_stat.order_above_req) begin
                    o_cmd.op = OP_SPLIT;
                    n_ret    = RET_PUSH;
                    n_state  = S_UREAD;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LOAD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
        // rebuild the store after any register write
        if (i_cfg_we) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ret    <= RET_PUSH;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_status <= n_status;
        end
    end

    `BPA_ASSERT_NR(a_rst_rebuild, i_clk, (!i_rst_n) |=> (r_state == S_CLEAR))
    `BPA_ASSERT(a_accept_check, i_clk, i_rst_n, (i_in_valid && o_in_ready && !i_cfg_we) |=> (r_state == S_CHECK))
    `BPA_ASSERT(a_load_out_free, i_clk, i_rst_n, (o_cmd.op == OP_LOAD_OUT) |-> i_stat.out_free)
    `BPA_ASSERT(a_unlink_data, i_clk, i_rst_n, (r_state == S_UA) |-> ($past(r_state) == S_UREAD || $past(r_state) == S_BCHK))
endmodule

### rtl/buddy_page_allocator.sv
// Buddy page allocator top level. One request at a time. An allocate takes a block from
// the lowest nonempty list of at least the requested order and splits it down to that
// order; a free merges the block with its buddy level by level while the buddy is free
// at the same order and the block is below the top order, then pushes it. A bad request
// or an empty pool is answered straight after the check, and a double free after the
// page's links are read. The controller returns to idle before the next request is taken.
// Each list step reads a page's links, unlinks it and pushes it, with one read and one
// write per link memory per cycle. After reset and after every register write the page
// store is rebuilt by a pass over all NUM_PAGES pages, one page per cycle, during which no
// request is taken. A finished result waits in an output register while the next request
// is taken; a result that is not yet taken holds the following one until the register frees.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int MAX_ORDER = 10,
    parameter int NUM_PAGES = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpa_req_if.sink               i_req,
    bpa_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_datapath #(
        .MAX_ORDER (MAX_ORDER),
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_req.func),
        .i_block_order (i_req.block_order),
        .i_page_number (i_req.page_number),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_page_out    (o_rsp.page_out),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );
endmodule
